### sv/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants
// Register indexes, sine polynomial coefficients and the per-beat sideband.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam logic [1:0] REG_RING_COUNT    = 2'd0;
  localparam logic [1:0] REG_SEGMENT_COUNT = 2'd1;
  localparam logic [1:0] REG_RADIUS        = 2'd2;

  localparam logic [8:0]  RESET_RING_COUNT    = 9'd16;
  localparam logic [8:0]  RESET_SEGMENT_COUNT = 9'd16;
  localparam logic [15:0] RESET_RADIUS        = 16'd256;

  // Q30 coefficients of the odd quarter-wave polynomial, innermost first
  localparam logic [31:0] SIN_C9 = 32'd172272;
  localparam logic [31:0] SIN_COEF [4] = '{
    32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [16:0] SINE_ONE     = 17'd32768;

  typedef struct packed {
    logic       valid;
    logic [1:0] corner;
    logic       last;
    logic       oor;
  } meta_t;

endpackage

### sv/uvs_delay.sv
// ----------------------------------------------------------------------------
// uvs_delay: stall-aware delay line
// Carries sideband bits alongside a pipelined unit, advancing on enable.
// ----------------------------------------------------------------------------
module uvs_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) taps[i] <= '0;
    end else if (en) begin
      taps[0] <= d;
      for (int i = 1; i < N; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[N-1];

endmodule

### sv/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div: pipelined restoring divider
// One quotient bit per stage; the caller guarantees quotient < 2**QW.
// ----------------------------------------------------------------------------
module uvs_div #(
  parameter int NW = 19,
  parameter int DW = 11,
  parameter int QW = 9
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rems [QW];
  logic [QW-1:0] quos [QW];
  logic [DW-1:0] dens [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [CW-1:0] rin;
    logic [QW-1:0] qin;
    logic [DW-1:0] din;
    logic [CW-1:0] sub;

    if (i == 0) begin : g_first
      assign rin = CW'(num);
      assign qin = '0;
      assign din = den;
    end else begin : g_next
      assign rin = rems[i-1];
      assign qin = quos[i-1];
      assign din = dens[i-1];
    end

    assign sub = CW'(din) << (QW - 1 - i);

    always_ff @(posedge clk) begin
      if (en) begin
        dens[i] <= din;
        if (rin >= sub) begin
          rems[i] <= rin - sub;
          quos[i] <= qin | (QW'(1) << (QW - 1 - i));
        end else begin
          rems[i] <= rin;
          quos[i] <= qin;
        end
      end
    end
  end

  assign quo = quos[QW-1];
  assign rem = rems[QW-1][DW-1:0];

endmodule

### sv/uvs_sine.sv
// ----------------------------------------------------------------------------
// uvs_sine: pipelined Q1.15 sine of a 16-bit phase
// Quadrant fold, square, four Horner steps, final multiply, cap and sign.
// ----------------------------------------------------------------------------
module uvs_sine (
  input  logic               clk,
  input  logic               en,
  input  logic        [15:0] phase,
  output logic signed [16:0] sine
);

  import uvs_pkg::*;

  logic [14:0] x0;
  logic        n0;
  logic [30:0] t2;
  logic [14:0] x1;
  logic        n1;
  logic [31:0] accs [4];
  logic [14:0] xs [4];
  logic        ns [4];
  logic [16:0] y6;
  logic        n6;
  logic [46:0] fin;
  logic [16:0] capped;

  // fold into the first quadrant, then square the folded phase
  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
      n0 <= phase[15];
      t2 <= (31'(x0) * 31'(x0)) << 2;
      x1 <= x0;
      n1 <= n0;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_horner
    logic [31:0] ain;
    logic [30:0] tin;
    logic [14:0] xin;
    logic        nin;
    logic [62:0] prod;
    logic [30:0] t_r;

    if (i == 0) begin : g_first
      assign ain = SIN_C9;
      assign tin = t2;
      assign xin = x1;
      assign nin = n1;
    end else begin : g_next
      assign ain = accs[i-1];
      assign tin = g_horner[i-1].t_r;
      assign xin = xs[i-1];
      assign nin = ns[i-1];
    end

    assign prod = 63'(tin) * 63'(ain);

    always_ff @(posedge clk) begin
      if (en) begin
        accs[i] <= SIN_COEF[i] - 32'(prod >> 30);
        t_r     <= tin;
        xs[i]   <= xin;
        ns[i]   <= nin;
      end
    end
  end

  assign fin    = 47'(xs[3]) * 47'(accs[3]) + (47'(1) << 28);
  assign capped = (y6 > SINE_ONE) ? SINE_ONE : y6;

  always_ff @(posedge clk) begin
    if (en) begin
      y6   <= fin[45:29];
      n6   <= ns[3];
      sine <= n6 ? -$signed(capped) : $signed(capped);
    end
  end

endmodule

### sv/uvs_scale.sv
// ----------------------------------------------------------------------------
// uvs_scale: position products
// Multiplies the sines, scales by the radius and rounds half away from zero.
// ----------------------------------------------------------------------------
module uvs_scale (
  input  logic               clk,
  input  logic               en,
  input  logic        [15:0] radius,
  input  logic signed [16:0] sin_r,
  input  logic signed [16:0] cos_r,
  input  logic signed [16:0] sin_s,
  input  logic signed [16:0] cos_s,
  output logic signed [16:0] px,
  output logic signed [16:0] py,
  output logic signed [16:0] pz
);

  logic signed [33:0] prx, prz;
  logic signed [16:0] cy;
  logic [30:0] mx, mz;
  logic [15:0] my;
  logic        sx, sy, sz;
  logic [46:0] rx, rz;
  logic [31:0] ry;
  logic        sx3, sy3, sz3;
  logic [47:0] ax, az;
  logic [32:0] ay;
  logic [16:0] qx, qy, qz;

  assign ax = 48'(rx) + (48'(1) << 29);
  assign az = 48'(rz) + (48'(1) << 29);
  assign ay = 33'(ry) + (33'(1) << 14);
  assign qx = ax[46:30];
  assign qz = az[46:30];
  assign qy = ay[31:15];

  always_ff @(posedge clk) begin
    if (en) begin
      prx <= sin_r * sin_s;
      prz <= sin_r * cos_s;
      cy  <= cos_r;
      // take magnitudes, keep signs
      sx  <= prx[33];
      sz  <= prz[33];
      sy  <= cy[16];
      mx  <= prx[33] ? 31'(-prx) : prx[30:0];
      mz  <= prz[33] ? 31'(-prz) : prz[30:0];
      my  <= cy[16] ? 16'(-cy) : cy[15:0];
      rx  <= 47'(mx) * 47'(radius);
      rz  <= 47'(mz) * 47'(radius);
      ry  <= 32'(my) * 32'(radius);
      sx3 <= sx;
      sy3 <= sy;
      sz3 <= sz;
      px  <= sx3 ? -$signed(qx) : $signed(qx);
      py  <= sy3 ? -$signed(qy) : $signed(qy);
      pz  <= sz3 ? -$signed(qz) : $signed(qz);
    end
  end

endmodule

### sv/uv_sphere_triangle_vertices.sv
// ----------------------------------------------------------------------------
// uv_sphere_triangle_vertices: UV sphere triangle-list vertex generator
// Turns a triangle index into its three vertex positions and texture coords.
// ----------------------------------------------------------------------------
// Usage:
//   Write ring_count, segment_count and radius on the cfg channel (index 0,
//   1, 2) while idle; cfg_ready is always high. Send triangle indexes on the
//   in channel. Each index gives three out beats (corner 0, 1, 2, last on the
//   third), or a single beat with out_of_range and last set when the index
//   is past the final triangle.
//   The expander issues one out beat per cycle while the receiver does not
//   stall: three per in-range index and one per out-of-range one. The next
//   index is taken in the cycle the current one issues its final vertex.
//   Path from input beat to output beat: index register, expander
//   register, 9-stage ring divider and its output register, 17-stage phase
//   dividers, 8-stage sine, 4-stage scaling and the output register.
//   A stalled receiver freezes the whole pipeline; nothing is dropped.
//   Reset empties the pipeline and loads the default registers (16, 16, 1.0).
// ----------------------------------------------------------------------------
module uv_sphere_triangle_vertices #(
  parameter int MAX_RINGS    = 256,
  parameter int MAX_SEGMENTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [17:0] triangle_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] tex_u,
  output logic        [15:0] tex_v,
  output logic        [1:0]  corner,
  output logic               out_of_range,
  output logic               last
);

  import uvs_pkg::*;

  logic [8:0]  ring_count, segment_count;
  logic [15:0] radius;
  logic [8:0]  nr, ns;
  logic [10:0] block;
  logic [19:0] ntri;
  logic        en;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count    <= RESET_RING_COUNT;
      segment_count <= RESET_SEGMENT_COUNT;
      radius        <= RESET_RADIUS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RING_COUNT:    ring_count    <= cfg_data[8:0];
        REG_SEGMENT_COUNT: segment_count <= cfg_data[8:0];
        REG_RADIUS:        radius        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ring_count == '0) nr = 9'd1;
    else if (32'(ring_count) > MAX_RINGS) nr = 9'(MAX_RINGS);
    else nr = ring_count;
    if (segment_count == '0) ns = 9'd1;
    else if (32'(segment_count) > MAX_SEGMENTS) ns = 9'(MAX_SEGMENTS);
    else ns = segment_count;
  end

  assign block = {10'(ns) + 10'd1, 1'b0};
  assign ntri  = {19'(nr) * (19'(ns) + 19'd1), 1'b0} - 20'd2;

  // expander: one triangle into three vertex beats, or one beat if out of range
  logic        busy, oor_r, done;
  logic [1:0]  cnt;
  logic [17:0] t_r;
  logic [18:0] k;

  assign en       = !out_valid || out_ready;
  assign done     = oor_r || (cnt == 2'd2);
  assign in_ready = !busy || (en && done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (en && busy) begin
      if (done) busy <= 1'b0;
      else cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      t_r   <= triangle_index;
      oor_r <= {2'b0, triangle_index} >= ntri;
    end
  end

  always_comb begin
    case (cnt)
      2'd0:    k = 19'(t_r);
      2'd1:    k = 19'(t_r) + (t_r[0] ? 19'd1 : 19'd2);
      2'd2:    k = 19'(t_r) + (t_r[0] ? 19'd2 : 19'd1);
      default: k = 19'(t_r);
    endcase
  end

  meta_t       a_meta;
  logic [18:0] a_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_meta <= '0;
    end else if (en) begin
      a_meta.valid  <= busy;
      a_meta.corner <= oor_r ? 2'd0 : cnt;
      a_meta.last   <= done;
      a_meta.oor    <= oor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) a_k <= k;
  end

  // ring and segment of the strip vertex
  logic [8:0]  q1;
  logic [10:0] r1;
  logic [$bits(meta_t):0] a_side, d1_side;

  uvs_div #(.NW(19), .DW(11), .QW(9)) u_div_ring (
    .clk (clk), .en (en), .num (a_k), .den (block), .quo (q1), .rem (r1)
  );

  assign a_side = {a_meta, a_k[0]};

  uvs_delay #(.W($bits(meta_t) + 1), .N(9)) u_dly_a (
    .clk (clk), .rst (rst), .en (en), .d (a_side), .q (d1_side)
  );

  meta_t      b_meta;
  logic [8:0] b_ring, b_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_meta <= '0;
    end else if (en) begin
      b_meta <= d1_side[$bits(meta_t):1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ring <= q1 + 9'(d1_side[0]);
      b_seg  <= r1[9:1];
    end
  end

  // phases and texture coordinates
  logic [24:0] n_ring, n_sph, n_tu;
  logic [16:0] q_ring, q_sph, q_tu;
  logic [8:0]  r_ring, r_sph, r_tu;

  assign n_ring = 25'({b_ring, 15'b0}) + 25'(nr >> 1);
  assign n_sph  = 25'({b_seg, 16'b0})  + 25'(ns >> 1);
  assign n_tu   = 25'({b_seg, 15'b0})  + 25'(ns >> 1);

  uvs_div #(.NW(25), .DW(9), .QW(17)) u_div_rph (
    .clk (clk), .en (en), .num (n_ring), .den (nr), .quo (q_ring), .rem (r_ring)
  );
  uvs_div #(.NW(25), .DW(9), .QW(17)) u_div_sph (
    .clk (clk), .en (en), .num (n_sph), .den (ns), .quo (q_sph), .rem (r_sph)
  );
  uvs_div #(.NW(25), .DW(9), .QW(17)) u_div_tu (
    .clk (clk), .en (en), .num (n_tu), .den (ns), .quo (q_tu), .rem (r_tu)
  );

  meta_t       e_meta;
  logic [31:0] tex_in, tex_dly;

  uvs_delay #(.W($bits(meta_t)), .N(29)) u_dly_b (
    .clk (clk), .rst (rst), .en (en), .d (b_meta), .q (e_meta)
  );

  assign tex_in = {16'(-q_tu[15:0]), q_ring[15:0]};

  uvs_delay #(.W(32), .N(12)) u_dly_tex (
    .clk (clk), .rst (rst), .en (en), .d (tex_in), .q (tex_dly)
  );

  // sines and cosines of both angles
  logic signed [16:0] sin_r, cos_r, sin_s, cos_s;

  uvs_sine u_sin_r (
    .clk (clk), .en (en), .phase (q_ring[15:0]), .sine (sin_r)
  );
  uvs_sine u_cos_r (
    .clk (clk), .en (en), .phase (q_ring[15:0] + QUARTER_TURN), .sine (cos_r)
  );
  uvs_sine u_sin_s (
    .clk (clk), .en (en), .phase (q_sph[15:0]), .sine (sin_s)
  );
  uvs_sine u_cos_s (
    .clk (clk), .en (en), .phase (q_sph[15:0] + QUARTER_TURN), .sine (cos_s)
  );

  logic signed [16:0] px, py, pz;

  uvs_scale u_scale (
    .clk (clk), .en (en), .radius (radius),
    .sin_r (sin_r), .cos_r (cos_r), .sin_s (sin_s), .cos_s (cos_s),
    .px (px), .py (py), .pz (pz)
  );

  // output register; zero the payload of an out-of-range beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= e_meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corner       <= e_meta.corner;
      out_of_range <= e_meta.oor;
      last         <= e_meta.last;
      pos_x        <= e_meta.oor ? '0 : px;
      pos_y        <= e_meta.oor ? '0 : py;
      pos_z        <= e_meta.oor ? '0 : pz;
      tex_u        <= e_meta.oor ? '0 : $signed(tex_dly[31:16]);
      tex_v        <= e_meta.oor ? '0 : tex_dly[15:0];
    end
  end

endmodule

### tb/uv_sphere_triangle_vertices_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv_sphere_triangle_vertices_checker: vertex predictor and scoreboard
// Watches the cfg, in and out channels, keeps its own copy of the registers,
// predicts the vertices of every accepted triangle index and compares each
// out beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module uv_sphere_triangle_vertices_checker #(
  parameter int MAX_RINGS    = 256,
  parameter int MAX_SEGMENTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [17:0] triangle_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [16:0] pos_x,
  input  logic signed [16:0] pos_y,
  input  logic signed [16:0] pos_z,
  input  logic signed [15:0] tex_u,
  input  logic        [15:0] tex_v,
  input  logic        [1:0]  corner,
  input  logic               out_of_range,
  input  logic               last,
  output int                 errors,
  output int                 pending
);

  import uvs_pkg::*;

  typedef struct packed {
    logic [16:0] px;
    logic [16:0] py;
    logic [16:0] pz;
    logic [15:0] u;
    logic [15:0] v;
    logic [1:0]  crn;
    logic        oor;
    logic        lst;
  } vertex_t;

  vertex_t vertex_q[$];
  logic [8:0]  rings_r;
  logic [8:0]  segs_r;
  logic [15:0] rad_r;

  assign pending = vertex_q.size();

  function automatic void append_vertex(vertex_t vx);
    vertex_q.insert(vertex_q.size(), vx);
  endfunction

  function automatic longint unsigned clamp_count(logic [8:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // quarter-wave sine, x in 0..16384, Q1.15
  function automatic longint quarter_wave(longint unsigned x);
    longint unsigned t2, acc, y;
    t2 = (x * x) << 2;
    acc = SIN_C9;
    for (int i = 0; i < 4; i++)
      acc = longint'(SIN_COEF[i]) - ((t2 * acc) >> 30);
    y = (x * acc + (64'd1 << 28)) >> 29;
    if (y > 32768) y = 32768;
    return longint'(y);
  endfunction

  function automatic longint sine_of(longint unsigned phase);
    longint unsigned p, q, x;
    longint m;
    p = phase & 64'hFFFF;
    q = p >> 14;
    x = p & 64'h3FFF;
    if (q[0]) x = 16384 - x;
    m = quarter_wave(x);
    return q[1] ? -m : m;
  endfunction

  function automatic longint radius_scale(longint p, int shift);
    longint unsigned mag, r;
    mag = (p < 0) ? longint'(-p) : p;
    mag = mag * rad_r;
    r = (mag + (64'd1 << (shift - 1))) >> shift;
    return (p < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic vertex_t strip_vertex(longint unsigned k, longint unsigned nr,
                                           longint unsigned ns, int c);
    vertex_t vx;
    longint unsigned blk, ring, seg, rph, sph;
    longint sr, cr, ss, cs, tu, tv;
    blk = 2 * (ns + 1);
    ring = k / blk + (k & 1);
    seg = (k % blk) / 2;
    rph = (ring * 65536 + nr) / (2 * nr);
    sph = (seg * 65536 + ns / 2) / ns;
    sr = sine_of(rph);
    cr = sine_of(rph + 16384);
    ss = sine_of(sph);
    cs = sine_of(sph + 16384);
    tu = -longint'((seg * 32768 + ns / 2) / ns);
    tv = (ring * 32768 + nr / 2) / nr;
    vx.px = 17'(radius_scale(sr * ss, 30));
    vx.py = 17'(radius_scale(cr, 15));
    vx.pz = 17'(radius_scale(sr * cs, 30));
    vx.u = 16'(tu);
    vx.v = 16'(tv);
    vx.crn = 2'(c);
    vx.oor = 1'b0;
    vx.lst = (c == 2);
    return vx;
  endfunction

  task automatic predict_triangle(logic [17:0] t);
    longint unsigned nr, ns, ntri, k1, k2;
    vertex_t vx;
    nr = clamp_count(rings_r, MAX_RINGS);
    ns = clamp_count(segs_r, MAX_SEGMENTS);
    ntri = 2 * nr * (ns + 1) - 2;
    if (t >= ntri) begin
      vx = '0;
      vx.oor = 1'b1;
      vx.lst = 1'b1;
      append_vertex(vx);
    end else begin
      k1 = t[0] ? t + 1 : t + 2;
      k2 = t[0] ? t + 2 : t + 1;
      append_vertex(strip_vertex(t, nr, ns, 0));
      append_vertex(strip_vertex(k1, nr, ns, 1));
      append_vertex(strip_vertex(k2, nr, ns, 2));
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    vertex_t w;
    if (rst) begin
      rings_r <= RESET_RING_COUNT;
      segs_r <= RESET_SEGMENT_COUNT;
      rad_r <= RESET_RADIUS;
      vertex_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RING_COUNT: rings_r <= cfg_data[8:0];
          REG_SEGMENT_COUNT: segs_r <= cfg_data[8:0];
          REG_RADIUS: rad_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_triangle(triangle_index);
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          report_mismatch("predictions waiting", 0, 1);
        end else begin
          w = vertex_q.pop_front();
          if (pos_x !== $signed(w.px)) report_mismatch("pos_x", pos_x, $signed(w.px));
          if (pos_y !== $signed(w.py)) report_mismatch("pos_y", pos_y, $signed(w.py));
          if (pos_z !== $signed(w.pz)) report_mismatch("pos_z", pos_z, $signed(w.pz));
          if (tex_u !== $signed(w.u)) report_mismatch("tex_u", tex_u, $signed(w.u));
          if (tex_v !== w.v) report_mismatch("tex_v", tex_v, w.v);
          if (corner !== w.crn) report_mismatch("corner", corner, w.crn);
          if (out_of_range !== w.oor)
            report_mismatch("out_of_range", out_of_range, w.oor);
          if (last !== w.lst) report_mismatch("last", last, w.lst);
        end
      end
    end
  end

endmodule

### tb/uv_sphere_triangle_vertices_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv_sphere_triangle_vertices_test: top-level testbench
// Drives register settings and triangle indexes with random gaps and output
// stalls, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module uv_sphere_triangle_vertices_test;
  import uvs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [1:0]  cfg_index = REG_RING_COUNT;
  logic        [15:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [17:0] triangle_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic signed [15:0] tex_u;
  logic        [15:0] tex_v;
  logic        [1:0]  corner;
  logic               out_of_range, last;
  int                 errors, pending;
  int                 cycles = 0;
  bit                 stimulus_done = 1'b0;

  always #4 clk = ~clk;

  uv_sphere_triangle_vertices DUT (.*);

  uv_sphere_triangle_vertices_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** uv_sphere_triangle_vertices: FAILED **");
      $finish;
    end
  end

  // receiver: stall a random number of cycles before each beat, sometimes none
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stimulus_done && $urandom_range(0, 1)) gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold valid after the beat; the next call either replaces the payload
  // or drops valid for its gap
  task automatic send_triangle(logic [17:0] t, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    triangle_index <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(logic [15:0] rings, logic [15:0] segs, logic [15:0] rad);
    wait_idle();
    write_reg(REG_RING_COUNT, rings);
    write_reg(REG_SEGMENT_COUNT, segs);
    write_reg(REG_RADIUS, rad);
  endtask

  // mostly in-range indexes for the current shape, some past the end
  task automatic random_run(int count, int rings, int segs);
    int ntri;
    bit burst;
    ntri = 2 * rings * (segs + 1) - 2;
    burst = $urandom_range(0, 4) == 0;
    for (int i = 0; i < count; i++) begin
      if (i % 12 == 0) burst = $urandom_range(0, 4) == 0;
      case ($urandom_range(0, 9))
        0: send_triangle(18'($urandom), burst);
        1: send_triangle(18'(ntri + $urandom_range(0, 3)), burst);
        2: send_triangle(18'(ntri - 1 - $urandom_range(0, 2)), burst);
        default: send_triangle(18'($urandom_range(0, ntri - 1)), burst);
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset shape: 16 x 16, unit radius
    send_triangle(18'd0, 1'b0);
    send_triangle(18'd1, 1'b0);
    send_triangle(18'd33, 1'b1);
    send_triangle(18'd542, 1'b1);
    send_triangle(18'd543, 1'b0);
    send_triangle(18'h3FFFF, 1'b0);
    // zero counts act as one; write to an unknown register is dropped
    set_shape(16'd0, 16'd0, 16'hFFFF);
    write_reg(2'd3, 16'h1234);
    send_triangle(18'd0, 1'b0);
    send_triangle(18'd1, 1'b0);
    send_triangle(18'd2, 1'b1);
    // oversized counts clamp to the maximum
    set_shape(16'h01FF, 16'h01FF, 16'd0);
    send_triangle(18'd131581, 1'b0);
    send_triangle(18'd131580, 1'b1);
    send_triangle(18'd131582, 1'b0);
    send_triangle(18'h2AAAA, 1'b0);
    set_shape(16'd256, 16'd256, 16'hFFFF);
    send_triangle(18'd131581, 1'b0);
    send_triangle(18'd65790, 1'b0);
    send_triangle(18'h15555, 1'b0);
    set_shape(16'd3, 16'd4, 16'hFFFF);
    send_triangle(18'd5, 1'b0);
    send_triangle(18'd28, 1'b0);
    send_triangle(18'd29, 1'b0);

    random_run(60, 3, 4);
    set_shape(16'd16, 16'd16, 16'd256);
    random_run(50, 16, 16);
    set_shape(16'd1, 16'd1, 16'($urandom));
    random_run(20, 1, 1);
    set_shape(16'd256, 16'd256, 16'h8000);
    random_run(40, 256, 256);
    set_shape(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)), 16'($urandom));
    random_run(40, checker_i.rings_r, checker_i.segs_r);

    stimulus_done = 1'b1;
    wait_idle();
    if (errors == 0) begin
      $display("** uv_sphere_triangle_vertices: PASSED **");
    end else begin
      $display("** uv_sphere_triangle_vertices: FAILED **");
    end
    $finish;
  end

endmodule
